FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/psknn_pkg.sv
// shared defaults and types for the point set k-nearest-neighbor block
// no dependencies
package psknn_pkg;

    localparam int MAX_POINTS_DEF    = 256;
    localparam int MAX_NEIGHBORS_DEF = 16;
    localparam int COORD_BITS_DEF    = 16;

    // control from the sequencer to the neighbor list
    typedef struct packed {
        logic clear;
        logic ins;
    } t_list_ctl;

endpackage

FILE: rtl/psknn_dist.sv
// squared euclidean distance pipeline: abs difference, square, sum
// depends on nothing but its parameters
module psknn_dist #(
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 8,
    localparam int DIST_W    = 2 * COORD_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output logic                         o_vld,
    output logic [IDX_W-1:0]             o_idx,
    output logic [DIST_W-1:0]            o_dist,
    output logic                         o_busy
);

    localparam int CW1 = COORD_BITS + 1;
    localparam int SQW = 2 * COORD_BITS;

    logic signed [CW1-1:0]  w_dx;
    logic signed [CW1-1:0]  w_dy;
    logic signed [CW1-1:0]  w_adx;
    logic signed [CW1-1:0]  w_ady;
    logic                   r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]       r_idx1, r_idx2, r_idx3;
    logic [COORD_BITS-1:0]  r_dx, r_dy;
    logic [SQW-1:0]         r_sqx, r_sqy;
    logic [DIST_W-1:0]      r_dist;

    always_comb begin
        w_dx  = CW1'(i_px) - CW1'(i_qx);
        w_dy  = CW1'(i_py) - CW1'(i_qy);
        w_adx = w_dx[CW1-1] ? -w_dx : w_dx;
        w_ady = w_dy[CW1-1] ? -w_dy : w_dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_dx   <= w_adx[COORD_BITS-1:0];
        r_dy   <= w_ady[COORD_BITS-1:0];
        r_idx2 <= r_idx1;
        r_sqx  <= SQW'(r_dx) * SQW'(r_dx);
        r_sqy  <= SQW'(r_dy) * SQW'(r_dy);
        r_idx3 <= r_idx2;
        r_dist <= DIST_W'(r_sqx) + DIST_W'(r_sqy);
    end

    assign o_vld  = r_v3;
    assign o_idx  = r_idx3;
    assign o_dist = r_dist;
    assign o_busy = r_v1 | r_v2 | r_v3;

endmodule

FILE: rtl/psknn_list.sv
// sorted neighbor list: parallel insertion of one candidate per cycle
// depends on psknn_pkg and assert_macros.svh
module psknn_list #(
    parameter int SLOTS  = 16,
    parameter int IDX_W  = 8,
    parameter int DIST_W = 33,
    parameter int SEL_W  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psknn_pkg::t_list_ctl i_ctl,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [DIST_W-1:0]    i_dist,
    input  logic [SEL_W-1:0]     i_rd_sel,
    output logic                 o_rd_vld,
    output logic [IDX_W-1:0]     o_rd_idx,
    output logic [DIST_W-1:0]    o_rd_dist
);
    import psknn_pkg::*;
    `include "assert_macros.svh"

    logic [SLOTS-1:0]  r_vld;
    logic [IDX_W-1:0]  r_idx  [SLOTS];
    logic [DIST_W-1:0] r_dist [SLOTS];
    logic [SLOTS-1:0]  w_lt;
    logic [SLOTS:0]    w_vld_inc;

    // an empty slot counts as farther than any candidate; equal keeps the older entry
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            w_lt[j] = !r_vld[j] || (i_dist < r_dist[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.ins) begin
            if (w_lt[0]) begin
                r_vld[0] <= 1'b1;
            end
            for (int j = 1; j < SLOTS; j++) begin
                if (w_lt[j]) begin
                    r_vld[j] <= !w_lt[j-1] || r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (w_lt[0]) begin
                r_idx[0]  <= i_idx;
                r_dist[0] <= i_dist;
            end
            for (int j = 1; j < SLOTS; j++) begin
                if (w_lt[j]) begin
                    if (!w_lt[j-1]) begin
                        r_idx[j]  <= i_idx;
                        r_dist[j] <= i_dist;
                    end else begin
                        r_idx[j]  <= r_idx[j-1];
                        r_dist[j] <= r_dist[j-1];
                    end
                end
            end
        end
    end

    assign o_rd_vld  = r_vld[i_rd_sel];
    assign o_rd_idx  = r_idx[i_rd_sel];
    assign o_rd_dist = r_dist[i_rd_sel];

    assign w_vld_inc = {1'b0, r_vld} + (SLOTS+1)'(1);

    // filled slots always form a prefix of the list
    `ASSERT_IMPL(a_fill_prefix, i_clk, i_rst_n, 1'b1, $onehot0(w_vld_inc))
    // filled slots stay in non-decreasing distance order
    for (genvar g = 0; g < SLOTS - 1; g++) begin : g_order
        `ASSERT_IMPL(a_sorted, i_clk, i_rst_n, r_vld[g+1], r_dist[g] <= r_dist[g+1])
    end

endmodule

FILE: rtl/point_set_k_nearest_neighbors.sv
// top level: point store, scan sequencer and result stage
// depends on psknn_pkg, psknn_dist, psknn_list and assert_macros.svh
//
// Input channel (i_in_valid / o_in_stall) takes load and query requests.
// A load writes one point into the coordinate memory and gives no result.
// A query reads the queried point, then streams the stored points 0..n-1
// other than the queried one through one distance pipeline at one point
// per cycle (one memory read port), inserting each into a sorted list. The
// steps of a query are: fetch the queried point, scan, drain the pipeline,
// then load the k entries into the output register at one per cycle while
// the receiver does not stall. A bad query index gives a single error entry.
// o_in_stall stays high from acceptance of a query until its last entry is
// loaded into the output register. The output channel (o_out_valid /
// i_out_stall) is a register: a stall holds the entry and pauses the run.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always accepted and
// must be issued only while the block is idle. Reset clears control state
// and the registers to point_count 1 and neighbors_per_point 4; the point
// memory is not cleared and must be loaded before it is queried.
module point_set_k_nearest_neighbors #(
    parameter int MAX_POINTS    = psknn_pkg::MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = psknn_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = psknn_pkg::COORD_BITS_DEF,
    localparam int IDX_W  = $clog2(MAX_POINTS),
    localparam int CNT_W  = $clog2(MAX_POINTS + 1),
    localparam int K_W    = $clog2(MAX_NEIGHBORS + 1),
    localparam int RANK_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
    localparam int CFG_W  = (CNT_W > K_W) ? CNT_W : K_W,
    localparam int DIST_W = 2 * COORD_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [IDX_W-1:0]             i_point_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [IDX_W-1:0]             o_query_index,
    output logic [RANK_W-1:0]            o_rank,
    output logic [IDX_W-1:0]             o_neighbor_index,
    output logic [DIST_W-1:0]            o_distance_sq,
    output logic                         o_neighbor_valid,
    output logic                         o_query_error,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);
    import psknn_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_QFETCH = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    typedef enum logic {
        CFG_POINT_COUNT = 1'b0,
        CFG_NEIGHBORS   = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_point_count;
    logic [K_W-1:0]          r_npp;
    logic [IDX_W-1:0]        r_query_idx;
    logic                    r_err;
    logic [CNT_W-1:0]        r_scan;
    logic [RANK_W-1:0]       r_rank;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_rd_x, r_rd_y;
    logic [2*COORD_BITS-1:0] r_mem [MAX_POINTS];
    logic                    r_s0_vld;
    logic [IDX_W-1:0]        r_s0_idx;

    logic                    r_out_vld;
    logic [IDX_W-1:0]        r_out_qidx;
    logic [RANK_W-1:0]       r_out_rank;
    logic [IDX_W-1:0]        r_out_nidx;
    logic [DIST_W-1:0]       r_out_dist;
    logic                    r_out_nvld;
    logic                    r_out_err;
    logic                    r_out_last;

    logic [CNT_W-1:0]        w_n;
    logic [K_W-1:0]          w_k;
    logic                    w_in_acc;
    logic                    w_query_ok;
    logic                    w_out_free;
    logic                    w_last_rank;
    logic [IDX_W-1:0]        w_rd_addr;
    logic                    w_dist_vld;
    logic [IDX_W-1:0]        w_dist_idx;
    logic [DIST_W-1:0]       w_dist;
    logic                    w_dist_busy;
    t_list_ctl               w_list_ctl;
    logic                    w_slot_vld;
    logic [IDX_W-1:0]        w_slot_idx;
    logic [DIST_W-1:0]       w_slot_dist;

    // effective point count and list length
    always_comb begin
        w_n = (r_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_point_count;
        if (r_npp == '0) begin
            w_k = K_W'(1);
        end else if (r_npp > K_W'(MAX_NEIGHBORS)) begin
            w_k = K_W'(MAX_NEIGHBORS);
        end else begin
            w_k = r_npp;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_query_ok  = CNT_W'(i_point_index) < w_n;
    assign w_out_free  = !r_out_vld || !i_out_stall;
    assign w_last_rank = (K_W'(r_rank) == (w_k - K_W'(1)));
    assign w_rd_addr   = (r_state == S_QFETCH) ? r_query_idx : r_scan[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && t_req'(i_req_type) == REQ_QUERY) begin
                    n_state = w_query_ok ? S_QFETCH : S_EMIT;
                end
            end
            S_QFETCH: n_state = S_SCAN;
            S_SCAN: begin
                if (r_scan == w_n - CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_s0_vld && !w_dist_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && (r_err || w_last_rank)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= CNT_W'(1);
            r_npp         <= K_W'(4);
            r_s0_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_err         <= 1'b0;
            r_scan        <= '0;
            r_rank        <= '0;
        end else begin
            r_state  <= n_state;
            r_s0_vld <= (r_state == S_SCAN) && (r_scan[IDX_W-1:0] != r_query_idx);
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_POINT_COUNT: r_point_count <= i_cfg_data[CNT_W-1:0];
                    CFG_NEIGHBORS:   r_npp         <= i_cfg_data[K_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_err  <= !w_query_ok;
                r_scan <= '0;
                r_rank <= '0;
            end
            if (r_state == S_SCAN) begin
                r_scan <= r_scan + CNT_W'(1);
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_vld <= 1'b1;
                r_rank    <= r_rank + RANK_W'(1);
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // point memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc && t_req'(i_req_type) == REQ_LOAD
                && CNT_W'(i_point_index) < CNT_W'(MAX_POINTS)) begin
            r_mem[i_point_index] <= {i_coord_x, i_coord_y};
        end
        {r_rd_x, r_rd_y} <= r_mem[w_rd_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_query_idx <= i_point_index;
        end
        // the queried point sits in the read register on the first scan cycle
        if (r_state == S_SCAN && r_scan == '0) begin
            r_qx <= r_rd_x;
            r_qy <= r_rd_y;
        end
        r_s0_idx <= r_scan[IDX_W-1:0];
        if (r_state == S_EMIT && w_out_free) begin
            // an error run starts at rank 0, so the rank register is zero here
            r_out_qidx <= r_query_idx;
            r_out_rank <= r_rank;
            r_out_err  <= r_err;
            r_out_last <= r_err || w_last_rank;
            if (r_err) begin
                r_out_nidx <= '0;
                r_out_dist <= '0;
                r_out_nvld <= 1'b0;
            end else if (r_rank == '0) begin
                r_out_nidx <= r_query_idx;
                r_out_dist <= '0;
                r_out_nvld <= 1'b1;
            end else begin
                r_out_nidx <= w_slot_vld ? w_slot_idx : '0;
                r_out_dist <= w_slot_vld ? w_slot_dist : '0;
                r_out_nvld <= w_slot_vld;
            end
        end
    end

    psknn_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s0_vld),
        .i_idx   (r_s0_idx),
        .i_px    (r_rd_x),
        .i_py    (r_rd_y),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_vld   (w_dist_vld),
        .o_idx   (w_dist_idx),
        .o_dist  (w_dist),
        .o_busy  (w_dist_busy)
    );

    always_comb begin
        w_list_ctl.clear = w_in_acc && t_req'(i_req_type) == REQ_QUERY;
        w_list_ctl.ins   = w_dist_vld;
    end

    psknn_list #(
        .SLOTS  (MAX_NEIGHBORS),
        .IDX_W  (IDX_W),
        .DIST_W (DIST_W),
        .SEL_W  (RANK_W)
    ) u_list (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_list_ctl),
        .i_idx     (w_dist_idx),
        .i_dist    (w_dist),
        .i_rd_sel  (r_rank - RANK_W'(1)),
        .o_rd_vld  (w_slot_vld),
        .o_rd_idx  (w_slot_idx),
        .o_rd_dist (w_slot_dist)
    );

    assign o_out_valid      = r_out_vld;
    assign o_query_index    = r_out_qidx;
    assign o_rank           = r_out_rank;
    assign o_neighbor_index = r_out_nidx;
    assign o_distance_sq    = r_out_dist;
    assign o_neighbor_valid = r_out_nvld;
    assign o_query_error    = r_out_err;
    assign o_last           = r_out_last;

    // an error entry is a run of its own with no neighbor
    `ASSERT_IMPL(a_err_single, i_clk, i_rst_n, o_out_valid && o_query_error, o_last && !o_neighbor_valid)
    // the first entry of a good run is the queried point itself
    `ASSERT_IMPL(a_rank0_self, i_clk, i_rst_n, o_out_valid && !o_query_error && o_rank == '0, o_neighbor_index == o_query_index && o_distance_sq == '0)
    // candidates enter the distance pipeline only from the scan
    `ASSERT_NEXT(a_scan_only, i_clk, i_rst_n, r_state != S_SCAN, !r_s0_vld)

endmodule

FILE: bench/testbench.sv
// self-checking bench for point_set_k_nearest_neighbors: point loads, neighbor queries
// and register writes, each neighbor entry predicted in the bench and compared field by field
// depends on psknn_pkg and the rtl top level
module testbench;
    import psknn_pkg::*;

    localparam int NPTS        = MAX_POINTS_DEF;
    localparam int MAXK        = MAX_NEIGHBORS_DEF;
    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 300;

    typedef enum logic {REQ_LOAD = 1'b0, REQ_QUERY = 1'b1} t_req_kind;
    typedef enum logic {REG_POINT_COUNT = 1'b0, REG_LIST_LEN = 1'b1} t_cfg_reg;

    typedef struct {
        t_req_kind         kind;
        logic [7:0]        idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_request;

    typedef struct {
        logic [7:0]  qidx;
        logic [3:0]  rank;
        logic [7:0]  nb;
        logic [32:0] dsq;
        logic        valid;
        logic        err;
        logic        last;
    } t_neighbor_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_point_index = '0;
    logic signed [15:0] i_coord_x = '0;
    logic signed [15:0] i_coord_y = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_query_index;
    logic [3:0]  o_rank;
    logic [7:0]  o_neighbor_index;
    logic [32:0] o_distance_sq;
    logic        o_neighbor_valid;
    logic        o_query_error;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [8:0]  i_cfg_data = '0;

    point_set_k_nearest_neighbors dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_point_index    (i_point_index),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_query_index    (o_query_index),
        .o_rank           (o_rank),
        .o_neighbor_index (o_neighbor_index),
        .o_distance_sq    (o_distance_sq),
        .o_neighbor_valid (o_neighbor_valid),
        .o_query_error    (o_query_error),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // bench copy of the block state
    logic signed [15:0] pt_x [NPTS];
    logic signed [15:0] pt_y [NPTS];
    logic [8:0]  cfg_points = 9'd1;
    logic [4:0]  cfg_list_len = 5'd4;

    t_request        request_q [$];
    t_neighbor_entry neighbor_q [$];
    bit              loaded [NPTS];

    int  items_queued, items_taken;
    int  n_loads, n_queries, n_bad_queries, n_entries, n_settings;
    int  fail_count;
    int  idle_in, idle_out;
    int  send_gap, stall_left, hold_left;
    int  stuck_cycles;
    bit  in_taken;
    bit  hold_req;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at entry %0d: %s", n_entries, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [32:0] got,
                               input logic [32:0] want, input t_neighbor_entry e);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d (query %0d rank %0d)",
                                      name, got, want, e.qidx, e.rank));
    endtask

    // sorted neighbor list of one query (or its error entry), ties kept in scan order (lower index first)
    task automatic predict_neighbors(input logic [7:0] idx);
        int              n, k, filled, pos;
        longint          dx, dy;
        logic [32:0]     d;
        logic [32:0]     best_d [MAXK];
        logic [7:0]      best_i [MAXK];
        t_neighbor_entry e;
        n = (cfg_points > NPTS) ? NPTS : int'(cfg_points);
        e.qidx = idx;
        if (int'(idx) >= n) begin
            n_bad_queries++;
            e.rank  = '0;
            e.nb    = '0;
            e.dsq   = '0;
            e.valid = 1'b0;
            e.err   = 1'b1;
            e.last  = 1'b1;
            neighbor_q.push_back(e);
            return;
        end
        k = (cfg_list_len == 0) ? 1 : ((cfg_list_len > MAXK) ? MAXK : int'(cfg_list_len));
        filled = 0;
        for (int i = 0; i < n; i++) begin
            if (i == int'(idx))
                continue;
            dx = longint'(pt_x[i]) - longint'(pt_x[idx]);
            dy = longint'(pt_y[i]) - longint'(pt_y[idx]);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            d = dx * dx + dy * dy;
            pos = filled;
            while (pos > 0 && d < best_d[pos-1])
                pos--;
            if (pos < k - 1) begin
                for (int j = (filled < k - 1) ? filled : k - 2; j > pos; j--) begin
                    best_d[j] = best_d[j-1];
                    best_i[j] = best_i[j-1];
                end
                best_d[pos] = d;
                best_i[pos] = i;
                if (filled < k - 1)
                    filled++;
            end
        end
        e.err = 1'b0;
        for (int r = 0; r < k; r++) begin
            e.rank = r;
            e.last = (r == k - 1);
            if (r == 0) begin
                e.nb    = idx;
                e.dsq   = '0;
                e.valid = 1'b1;
            end else if (r - 1 < filled) begin
                e.nb    = best_i[r-1];
                e.dsq   = best_d[r-1];
                e.valid = 1'b1;
            end else begin
                e.nb    = '0;
                e.dsq   = '0;
                e.valid = 1'b0;
            end
            neighbor_q.push_back(e);
        end
    endtask

    // request transfers: update the point store or predict the neighbor run
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            in_taken = 1'b1;
            items_taken++;
            if (i_req_type == REQ_LOAD) begin
                n_loads++;
                pt_x[i_point_index] = i_coord_x;
                pt_y[i_point_index] = i_coord_y;
            end else begin
                n_queries++;
                predict_neighbors(i_point_index);
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin : drive_requests
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !in_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (idle_in != 0 && $urandom_range(1, 100) <= idle_in) begin
                send_gap = $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                req = request_q.pop_front();
                i_req_type    <= req.kind;
                i_point_index <= req.idx;
                i_coord_x     <= req.x;
                i_coord_y     <= req.y;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // result receiver stalls, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req || hold_left > 0) begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_out != 0 && $urandom_range(1, 100) <= idle_out) begin
            stall_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_neighbor_entry want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_entries++;
            if (neighbor_q.size() == 0) begin
                report_mismatch($sformatf("entry for query %0d rank %0d with nothing pending",
                                          o_query_index, o_rank));
            end else begin
                want = neighbor_q.pop_front();
                check_field("query_index", o_query_index, want.qidx, want);
                check_field("rank", o_rank, want.rank, want);
                check_field("neighbor_index", o_neighbor_index, want.nb, want);
                check_field("distance_sq", o_distance_sq, want.dsq, want);
                check_field("neighbor_valid", o_neighbor_valid, want.valid, want);
                check_field("query_error", o_query_error, want.err, want);
                check_field("last", o_last, want.last, want);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("no transfer for %0d cycles, %0d entries pending",
                     STUCK_LIMIT, neighbor_q.size());
            $display("testbench failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return $urandom_range(0, 65535);
        else if (mode < 9)
            return $urandom_range(0, 6) - 3;  // tight cluster, lots of equal distances
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    task automatic queue_load(input int idx, input logic signed [15:0] x,
                              input logic signed [15:0] y);
        t_request r;
        r.kind = REQ_LOAD;
        r.idx  = idx;
        r.x    = x;
        r.y    = y;
        request_q.push_back(r);
        loaded[idx[7:0]] = 1'b1;
        items_queued++;
    endtask

    task automatic queue_query(input int idx);
        t_request r;
        r.kind = REQ_QUERY;
        r.idx  = idx;
        r.x    = $urandom_range(0, 65535);
        r.y    = $urandom_range(0, 65535);
        request_q.push_back(r);
        items_queued++;
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [8:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (r == REG_POINT_COUNT)
            cfg_points = v;
        else
            cfg_list_len = v[4:0];
        n_settings++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // every request taken and every entry seen, then room for a trailing load
    task automatic wait_idle();
        while (items_taken != items_queued || neighbor_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_phase(input int pc, input int k, input int count, input int in_rate,
                             input int out_rate, input bit long_hold, input bit mid_pause);
        int n_eff;
        int pick;
        idle_in  = in_rate;
        idle_out = out_rate;
        write_reg(REG_POINT_COUNT, pc[8:0]);
        write_reg(REG_LIST_LEN, k[8:0]);
        n_eff = (pc > NPTS) ? NPTS : pc;
        // a query scans 0..n-1, so every one of them must hold a point
        for (int i = 0; i < n_eff; i++)
            if (!loaded[i])
                queue_load(i, rand_coord(), rand_coord());
        if (long_hold)
            hold_req = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (mid_pause && i == count / 2)
                wait_idle();
            if ($urandom_range(0, 9) < 3) begin
                if (n_eff == 0 || $urandom_range(0, 4) == 0)
                    pick = $urandom_range(0, NPTS - 1);
                else
                    pick = $urandom_range(0, n_eff - 1);
                queue_load(pick, rand_coord(), rand_coord());
            end else if (n_eff < NPTS && (n_eff == 0 || $urandom_range(0, 7) == 0)) begin
                queue_query($urandom_range(n_eff, NPTS - 1));
            end else begin
                queue_query($urandom_range(0, n_eff - 1));
            end
        end
        wait_idle();
    endtask

    initial begin
        idle_in  = 0;
        idle_out = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one point, lists of four
        queue_load(0, 16'sh8000, 16'sh7FFF);
        queue_query(0);
        queue_query(1);
        queue_query(255);
        wait_idle();

        // corners, duplicates and equal distances
        write_reg(REG_POINT_COUNT, 9'd6);
        write_reg(REG_LIST_LEN, 9'd6);
        queue_load(0, 16'sh8000, 16'sh8000);
        queue_load(1, 16'sh7FFF, 16'sh7FFF);
        queue_load(2, 16'sh0000, 16'sh0000);
        queue_load(3, 16'sh0000, 16'sh0000);
        queue_load(4, 16'sd100, -16'sd100);
        queue_load(5, -16'sd100, 16'sd100);
        queue_query(0);
        queue_query(1);
        queue_query(2);
        queue_query(5);
        queue_query(6);
        wait_idle();

        // list length zero and above the maximum, then no points at all
        write_reg(REG_LIST_LEN, 9'd0);
        queue_query(3);
        wait_idle();
        write_reg(REG_LIST_LEN, 9'd31);
        queue_query(4);
        wait_idle();
        write_reg(REG_POINT_COUNT, 9'd0);
        queue_query(0);
        wait_idle();

        run_phase(5, 3, 22, 10, 10, 1'b0, 1'b0);
        run_phase(12, 16, 22, 25, 5, 1'b0, 1'b1);
        run_phase(2, 1, 20, 0, 25, 1'b0, 1'b0);
        run_phase(24, 8, 22, 8, 8, 1'b1, 1'b0);
        run_phase(9, 31, 22, 25, 25, 1'b0, 1'b0);
        run_phase($urandom_range(1, 32), $urandom_range(0, 31), 22, 8, 25, 1'b0, 1'b0);
        run_phase(40, 10, 20, 25, 8, 1'b0, 1'b0);
        run_phase(1, 16, 15, 10, 10, 1'b0, 1'b0);
        run_phase(3, 4, 20, 0, 0, 1'b0, 1'b0);

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (neighbor_q.size() != 0)
            report_mismatch($sformatf("%0d entries never arrived", neighbor_q.size()));
        $display("run covered %0d loads and %0d queries (%0d out of range) over %0d register writes",
                 n_loads, n_queries, n_bad_queries, n_settings);
        $display("%0d neighbor entries checked, %0d mismatches", n_entries, fail_count);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
